/* hdl/itsp_pkg.sv */
// ----------------------------------------------------------------------------
// itsp_pkg: shared definitions of the interleaved transfer splitter
// Widths, register indexes and the divider command and response types.
// ----------------------------------------------------------------------------
package itsp_pkg;

   // Field widths of the request, the result and the registers.
   localparam int AddrW      = 48;
   localparam int BytesW     = 26;
   localparam int ChunkW     = 27;
   localparam int StripeW    = 13;
   localparam int SpanW      = 17;
   localparam int NodesW     = 11;
   localparam int MibShift   = 20;
   localparam int AddrMibW   = AddrW - MibShift;
   localparam int CsrIndexW  = 8;
   localparam int CsrDataW   = 32;
   localparam int ReqDataW   = 80;
   localparam int RspDataW   = 80;
   localparam int MaxResults = 64;
   localparam int CountW     = $clog2(MaxResults);

   // Default chunk cap in bytes (64 MiB).
   localparam int MaxChunkBytesDef = 64 * 1024 * 1024;

   // Register indexes.
   localparam logic [CsrIndexW-1:0] CsrStripe = 8'd0;
   localparam logic [CsrIndexW-1:0] CsrSpan   = 8'd1;
   localparam logic [CsrIndexW-1:0] CsrNodes  = 8'd2;

   // Divider operand widths: a MiB-granular address over a granule or node count.
   localparam int DivDividendW = AddrMibW;
   localparam int DivDivisorW  = SpanW;

   typedef struct packed {
      logic                    start;
      logic [DivDividendW-1:0] dividend;
      logic [DivDivisorW-1:0]  divisor;
   } itsp_div_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [DivDividendW-1:0] quotient;
      logic [DivDivisorW-1:0]  remainder;
   } itsp_div_rsp_type;

endpackage

/* hdl/itsp_div.sv */
// ----------------------------------------------------------------------------
// itsp_div: shared restoring divider
// Produces one quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module itsp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  itsp_pkg::itsp_div_cmd_type cmd,
   output itsp_pkg::itsp_div_rsp_type rsp
);
   import itsp_pkg::*;

   localparam int StepW = $clog2(DivDividendW);
   localparam logic [StepW-1:0] LastStep = StepW'(DivDividendW - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic [DivDividendW-1:0] quo_ff, quo_in;
   logic [DivDivisorW-1:0]  rem_ff, rem_in;
   logic [DivDivisorW-1:0]  divisor_ff, divisor_in;
   logic [DivDivisorW:0]    trial;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[DivDividendW-1]} - {1'b0, divisor_ff};
      if (cmd.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quo_in     = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         if (!trial[DivDivisorW]) begin
            rem_in = trial[DivDivisorW-1:0];
            quo_in = {quo_ff[DivDividendW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivDivisorW-2:0], quo_ff[DivDividendW-1]};
            quo_in = {quo_ff[DivDividendW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; operands are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* hdl/interleaved_transfer_splitter.sv */
// ----------------------------------------------------------------------------
// interleaved_transfer_splitter: cuts a transfer request into mapped chunks
// Splits a request at the chunk cap and at stripe or node-span boundaries and
// maps each chunk's logical address onto the interleaved node layout.
// ----------------------------------------------------------------------------
// One request at a time is worked on; req_tready is high only while the
// sequencer is idle. When interleaving is on, each chunk goes through a setup
// step, two 28-step divisions in the shared divider, two multiply steps and
// one step to form the result; with only a node span set it takes one
// division, and with neither it goes straight from setup to forming the
// result. A request yields at most 64 chunks, and the result side can hold
// the sequencer off while the output register is full. The divider is the
// bound: it yields one quotient bit per cycle. A finished chunk waits in the
// output register while the next one is being worked out, and a new request
// is taken while the last chunk of the previous one is still waiting there.
module interleaved_transfer_splitter #(
   parameter int MAX_CHUNK_BYTES = itsp_pkg::MaxChunkBytesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [47:0] start_address, [73:48] transfer_bytes, [79:74] zero
   input  logic [itsp_pkg::ReqDataW-1:0] req_tdata,
   // [0] write_req
   input  logic                          req_tuser,
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [47:0] phys_address, [74:48] chunk_bytes, [79:75] zero
   output logic [itsp_pkg::RspDataW-1:0] rsp_tdata,
   // [0] write_out
   output logic                          rsp_tuser,
   // last_chunk
   output logic                          rsp_tlast,
   // Register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [itsp_pkg::CsrIndexW-1:0] csr_index,
   input  logic [itsp_pkg::CsrDataW-1:0]  csr_data
);
   import itsp_pkg::*;

   localparam logic [ChunkW-1:0] MaxChunk = ChunkW'(MAX_CHUNK_BYTES);

   // Sequencer states.
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StStart = 3'd1;
   localparam logic [2:0] StDiv1  = 3'd2;
   localparam logic [2:0] StDiv2  = 3'd3;
   localparam logic [2:0] StMulA  = 3'd4;
   localparam logic [2:0] StMulB  = 3'd5;
   localparam logic [2:0] StCalc  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [StripeW-1:0]     stripe_ff, stripe_in;
   logic [SpanW-1:0]       span_ff, span_in;
   logic [NodesW-1:0]      nodes_ff, nodes_in;
   logic [AddrW-1:0]       addr_ff, addr_in;
   logic [BytesW-1:0]      remain_ff, remain_in;
   logic                   wr_ff, wr_in;
   logic [CountW-1:0]      count_ff, count_in;
   logic [SpanW-1:0]       gran_ff, gran_in;
   logic                   gran_nz_ff, gran_nz_in;
   logic [AddrMibW-1:0]    stripe_no_ff, stripe_no_in;
   logic [SpanW-1:0]       offset_mib_ff, offset_mib_in;
   logic [AddrMibW-1:0]    local_ff, local_in;
   logic [NodesW-1:0]      node_ff, node_in;
   logic [AddrMibW-1:0]    node_term_ff, node_term_in;
   logic [AddrMibW-1:0]    local_term_ff, local_term_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AddrW-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [ChunkW-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic                   rsp_wr_ff, rsp_wr_in;
   logic                   rsp_last_ff, rsp_last_in;

   itsp_div_cmd_type       div_cmd;
   itsp_div_rsp_type       div_rsp;

   logic                   interleave;
   logic                   req_fire;
   logic                   out_free;
   logic                   out_load;
   logic [AddrMibW+SpanW-1:0] mul_a_x_b;
   logic [AddrMibW-1:0]    mul_a;
   logic [SpanW-1:0]       mul_b;
   logic [ChunkW-1:0]      cap;
   logic [SpanW-1:0]       edge_mib;
   logic [SpanW+MibShift-1:0] to_edge;
   logic [ChunkW-1:0]      chunk;
   logic [BytesW-1:0]      remain_next;
   logic [AddrMibW-1:0]    phys_mib;

   itsp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign interleave = (stripe_ff != '0) && (nodes_ff >= NodesW'(2));
   assign req_tready = (state_ff == StIdle);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == StCalc) && out_free;

   // Shared multiplier: node times span, then local stripe times stripe size.
   always_comb begin
      if (state_ff == StMulA) begin
         mul_a = AddrMibW'(node_ff);
         mul_b = span_ff;
      end else begin
         mul_a = local_ff;
         mul_b = SpanW'(stripe_ff);
      end
      mul_a_x_b = {{SpanW{1'b0}}, mul_a} * {{AddrMibW{1'b0}}, mul_b};
   end

   // Chunk length: the smallest of what is left, the cap and, when a granule is
   // set, the distance to the next granule boundary.
   always_comb begin
      cap         = ({1'b0, remain_ff} > MaxChunk) ? MaxChunk : {1'b0, remain_ff};
      edge_mib    = gran_ff - offset_mib_ff;
      to_edge     = {edge_mib, {MibShift{1'b0}}}
                    - {{SpanW{1'b0}}, addr_ff[MibShift-1:0]};
      if (gran_nz_ff && ({{(SpanW+MibShift-ChunkW){1'b0}}, cap} > to_edge)) begin
         chunk = to_edge[ChunkW-1:0];
      end else begin
         chunk = cap;
      end
      remain_next = remain_ff - chunk[BytesW-1:0];
      if (interleave) begin
         phys_mib = node_term_ff + local_term_ff + AddrMibW'(offset_mib_ff);
      end else begin
         phys_mib = addr_ff[AddrW-1:MibShift];
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      stripe_in     = stripe_ff;
      span_in       = span_ff;
      nodes_in      = nodes_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      gran_in       = gran_ff;
      gran_nz_in    = gran_nz_ff;
      stripe_no_in  = stripe_no_ff;
      offset_mib_in = offset_mib_ff;
      local_in      = local_ff;
      node_in       = node_ff;
      node_term_in  = node_term_ff;
      local_term_in = local_term_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_wr_in     = rsp_wr_ff;
      rsp_last_in   = rsp_last_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = addr_ff[AddrW-1:MibShift];
      div_cmd.divisor  = gran_ff;

      // Register writes; an index past the list is dropped.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrStripe: stripe_in = csr_data[StripeW-1:0];
            CsrSpan:   span_in   = csr_data[SpanW-1:0];
            CsrNodes:  nodes_in  = csr_data[NodesW-1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               addr_in   = req_tdata[AddrW-1:0];
               remain_in = req_tdata[AddrW+BytesW-1:AddrW];
               wr_in     = req_tuser;
               count_in  = '0;
               if (req_tdata[AddrW+BytesW-1:AddrW] != '0) begin
                  state_in = StStart;
               end
            end
         end
         StStart: begin
            // Pick the granule and, if there is one, divide the MiB address by it.
            if (interleave) begin
               gran_in = SpanW'(stripe_ff);
            end else begin
               gran_in = span_ff;
            end
            gran_nz_in    = interleave || (span_ff != '0);
            offset_mib_in = '0;
            if (interleave || (span_ff != '0)) begin
               div_cmd.start   = 1'b1;
               div_cmd.divisor = interleave ? SpanW'(stripe_ff) : span_ff;
               state_in        = StDiv1;
            end else begin
               state_in = StCalc;
            end
         end
         StDiv1: begin
            if (div_rsp.done) begin
               stripe_no_in  = div_rsp.quotient;
               offset_mib_in = div_rsp.remainder;
               if (interleave) begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = div_rsp.quotient;
                  div_cmd.divisor  = SpanW'(nodes_ff);
                  state_in         = StDiv2;
               end else begin
                  state_in = StCalc;
               end
            end
         end
         StDiv2: begin
            // Deal the stripe number over the nodes.
            if (div_rsp.done) begin
               local_in = div_rsp.quotient;
               node_in  = div_rsp.remainder[NodesW-1:0];
               state_in = StMulA;
            end
         end
         StMulA: begin
            node_term_in = mul_a_x_b[AddrMibW-1:0];
            state_in     = StMulB;
         end
         StMulB: begin
            local_term_in = mul_a_x_b[AddrMibW-1:0];
            state_in      = StCalc;
         end
         StCalc: begin
            // Hand the chunk to the output register once it is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = {phys_mib, addr_ff[MibShift-1:0]};
               rsp_bytes_in = chunk;
               rsp_wr_in    = wr_ff;
               rsp_last_in  = (remain_next == '0) || (count_ff == CountW'(MaxResults - 1));
               remain_in    = remain_next;
               addr_in      = addr_ff + {{(AddrW-ChunkW){1'b0}}, chunk};
               count_in     = count_ff + 1'b1;
               if ((remain_next == '0) || (count_ff == CountW'(MaxResults - 1))) begin
                  state_in = StIdle;
               end else begin
                  state_in = StStart;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         stripe_ff    <= '0;
         span_ff      <= '0;
         nodes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stripe_ff    <= stripe_in;
         span_ff      <= span_in;
         nodes_ff     <= nodes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      wr_ff         <= wr_in;
      count_ff      <= count_in;
      gran_ff       <= gran_in;
      gran_nz_ff    <= gran_nz_in;
      stripe_no_ff  <= stripe_no_in;
      offset_mib_ff <= offset_mib_in;
      local_ff      <= local_in;
      node_ff       <= node_in;
      node_term_ff  <= node_term_in;
      local_term_ff <= local_term_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_wr_ff     <= rsp_wr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-AddrW-ChunkW){1'b0}}, rsp_bytes_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_wr_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // A chunk handed out is never empty and never above the cap.
   a_chunk_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_bytes_ff != '0) && (rsp_bytes_ff <= MaxChunk))
      else $error("chunk length out of range");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == StDiv1) || (state_ff == StDiv2))
      else $error("divider finished outside a divide step");

   // No new request is taken while the divider is still working.
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("request accepted while divider busy");

   // A loaded chunk shows up on the result channel in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded chunk not presented");
`endif

endmodule
